FILE: rtl/core/msst_pkg.sv
// Shared types and constants for the multi-slot timer array.
`default_nettype none
package msst_pkg;

  localparam int SLOTS   = 16;
  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int CMP_W   = (CNT_W > 4) ? CNT_W : 4;
  localparam int FIRED_W = 16;

  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_REGISTER = 3'd1,
    OP_START    = 3'd2,
    OP_STOP     = 3'd3,
    OP_RESTART  = 3'd4
  } op_e_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } state_t;

  // Command token that walks down the row of cells, one cell per cycle.
  typedef struct packed {
    logic               vld;
    op_e_t              op;
    logic               en;      // addressed operation targets a valid slot
    logic [SLOT_W-1:0]  tgt;
    logic [31:0]        period;
    logic [31:0]        delay;
    logic               ok;
    logic [FIRED_W-1:0] fired;
  } tok_t;

endpackage
`default_nettype wire

FILE: rtl/core/msst_cell.sv
// One timer slot: holds its state and acts on the command token passing by.
`default_nettype none
module msst_cell (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [msst_pkg::SLOT_W-1:0] cell_idx,
  input  wire msst_pkg::tok_t              tok_i,
  output msst_pkg::tok_t                   tok_o
);

  logic        reg_r, reg_nxt;
  logic        act_r, act_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic [31:0] per_r, per_nxt;
  logic [31:0] dly_r, dly_nxt;
  msst_pkg::tok_t tok_r, tok_nxt;

  logic hit;
  logic fire;

  assign hit = tok_i.en && (tok_i.tgt == cell_idx);

  always_comb begin
    reg_nxt = reg_r;
    act_nxt = act_r;
    cnt_nxt = cnt_r;
    per_nxt = per_r;
    dly_nxt = dly_r;
    tok_nxt = tok_i;
    fire    = 1'b0;
    if (tok_i.vld) begin
      unique case (tok_i.op)
        msst_pkg::OP_TICK: begin
          if (reg_r && act_r) begin
            if (cnt_r != 32'd0) begin
              cnt_nxt = cnt_r - 32'd1;
            end else begin
              fire = 1'b1;
              if (per_r == 32'd0) begin
                act_nxt = 1'b0;
              end else begin
                cnt_nxt = per_r - 32'd1;
              end
            end
          end
        end
        msst_pkg::OP_REGISTER: begin
          if (hit) begin
            reg_nxt = 1'b1;
            act_nxt = 1'b0;
            per_nxt = tok_i.period;
            dly_nxt = tok_i.delay;
          end
        end
        msst_pkg::OP_START: begin
          if (hit && !act_r) begin
            cnt_nxt    = dly_r;
            act_nxt    = 1'b1;
            tok_nxt.ok = 1'b1;
          end
        end
        msst_pkg::OP_STOP: begin
          if (hit) begin
            act_nxt = 1'b0;
          end
        end
        msst_pkg::OP_RESTART: begin
          if (hit) begin
            cnt_nxt = dly_r;
            act_nxt = 1'b1;
          end
        end
        default: ;
      endcase
    end
    // only the low 16 slots show up in the fired mask
    for (int b = 0; b < msst_pkg::FIRED_W; b++) begin
      if (fire && (msst_pkg::CMP_W'(cell_idx) == msst_pkg::CMP_W'(b))) begin
        tok_nxt.fired[b] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_r <= 1'b0;
      act_r <= 1'b0;
      cnt_r <= '0;
      per_r <= '0;
      dly_r <= '0;
      tok_r <= '0;
    end else begin
      reg_r <= reg_nxt;
      act_r <= act_nxt;
      cnt_r <= cnt_nxt;
      per_r <= per_nxt;
      dly_r <= dly_nxt;
      tok_r <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule
`default_nettype wire

FILE: rtl/core/multi_slot_software_timer.sv
// Top level of the timer array: command launch, slot allocation, result register.
//
//   channel | ports                                    | handshake
//   --------+------------------------------------------+---------------------
//   input   | in_op, in_slot, in_period, in_delay      | in_valid / in_ready
//   result  | out_ok, out_new_slot, out_fired_mask     | out_valid / out_ready
//
// Each transaction walks the row of SLOTS cells, one cell per cycle: its result is
// then registered in the result register, and in_ready returns once that load is
// done, so a new item is accepted only after the last one has left the row.
// One item is in the row at a time. If the previous result still waits on out_ready,
// the new one parks in a one-deep holding register and in_ready stays low meanwhile.
// Synchronous active-low reset clears all slots (no slot registered or active).
`default_nettype none
module multi_slot_software_timer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_op,
  input  wire logic [3:0]  in_slot,
  input  wire logic [31:0] in_period,
  input  wire logic [31:0] in_delay,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_ok,
  output logic [3:0]       out_new_slot,
  output logic [15:0]      out_fired_mask
);

  msst_pkg::state_t state_r, state_nxt;
  logic [msst_pkg::CNT_W-1:0] slot_count_r, slot_count_nxt;
  logic [3:0]  new_r, new_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_ok_r, out_ok_nxt;
  logic [3:0]  out_new_r, out_new_nxt;
  logic [15:0] out_fired_r, out_fired_nxt;
  logic        pend_ok_r;
  logic [15:0] pend_fired_r;

  msst_pkg::tok_t chain [msst_pkg::SLOTS+1];
  msst_pkg::tok_t launch;

  logic acc;
  logic chain_end;
  logic out_load;
  logic pend_load;
  logic slot_ok;
  logic reg_ok;
  logic [msst_pkg::CMP_W-1:0] slot_ext;

  assign chain_end = chain[msst_pkg::SLOTS].vld;
  assign slot_ext  = msst_pkg::CMP_W'(in_slot);
  assign slot_ok   = slot_ext < msst_pkg::CMP_W'(slot_count_r);
  assign reg_ok    = (slot_count_r < msst_pkg::CNT_W'(msst_pkg::SLOTS)) &&
                     !((in_period == 32'd0) && (in_delay == 32'd0));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      msst_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = msst_pkg::ST_RUN;
        end
      end
      msst_pkg::ST_RUN: begin
        if (chain_end) begin
          if (!out_valid_r || out_ready) begin
            state_nxt = msst_pkg::ST_IDLE;
          end else begin
            state_nxt = msst_pkg::ST_HOLD;
          end
        end
      end
      msst_pkg::ST_HOLD: begin
        if (out_ready) begin
          state_nxt = msst_pkg::ST_IDLE;
        end
      end
      default: state_nxt = msst_pkg::ST_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    in_ready  = 1'b0;
    out_load  = 1'b0;
    pend_load = 1'b0;
    unique case (state_r)
      msst_pkg::ST_IDLE: in_ready = 1'b1;
      msst_pkg::ST_RUN: begin
        pend_load = chain_end;
        out_load  = chain_end && (!out_valid_r || out_ready);
      end
      msst_pkg::ST_HOLD: out_load = out_ready;
      default: ;
    endcase
  end

  assign acc = in_valid && in_ready;

  // build the token that enters the first cell
  always_comb begin
    launch         = '0;
    launch.vld     = acc;
    launch.op      = msst_pkg::op_e_t'(in_op);
    launch.period  = in_period;
    launch.delay   = in_delay;
    launch.tgt     = slot_ext[msst_pkg::SLOT_W-1:0];
    slot_count_nxt = slot_count_r;
    new_nxt        = new_r;
    if (acc) begin
      new_nxt = 4'd0;
      unique case (msst_pkg::op_e_t'(in_op))
        msst_pkg::OP_TICK: launch.ok = 1'b1;
        msst_pkg::OP_REGISTER: begin
          launch.tgt = slot_count_r[msst_pkg::SLOT_W-1:0];
          launch.en  = reg_ok;
          launch.ok  = reg_ok;
          if (reg_ok) begin
            slot_count_nxt = slot_count_r + msst_pkg::CNT_W'(1);
            new_nxt        = 4'(slot_count_r);
          end
        end
        msst_pkg::OP_START: launch.en = slot_ok;
        msst_pkg::OP_STOP, msst_pkg::OP_RESTART: begin
          launch.en = slot_ok;
          launch.ok = slot_ok;
        end
        default: ;
      endcase
    end
  end

  assign chain[0] = launch;

  for (genvar g = 0; g < msst_pkg::SLOTS; g++) begin : g_cell
    msst_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (msst_pkg::SLOT_W'(g)),
      .tok_i    (chain[g]),
      .tok_o    (chain[g+1])
    );
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_ok_nxt    = out_ok_r;
    out_new_nxt   = out_new_r;
    out_fired_nxt = out_fired_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_new_nxt   = new_r;
      if (state_r == msst_pkg::ST_HOLD) begin
        out_ok_nxt    = pend_ok_r;
        out_fired_nxt = pend_fired_r;
      end else begin
        out_ok_nxt    = chain[msst_pkg::SLOTS].ok;
        out_fired_nxt = chain[msst_pkg::SLOTS].fired;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= msst_pkg::ST_IDLE;
      slot_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      slot_count_r <= slot_count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    new_r       <= new_nxt;
    out_ok_r    <= out_ok_nxt;
    out_new_r   <= out_new_nxt;
    out_fired_r <= out_fired_nxt;
    if (pend_load) begin
      pend_ok_r    <= chain[msst_pkg::SLOTS].ok;
      pend_fired_r <= chain[msst_pkg::SLOTS].fired;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ok         = out_ok_r;
  assign out_new_slot   = out_new_r;
  assign out_fired_mask = out_fired_r;

endmodule
`default_nettype wire
